// File: hw/rtl/slip_crc8_frame_receiver_top_macros.svh
// ---------------------------------------------------------------------------
// SLIP CRC-8 frame receiver: assertion macros
// Clocked assertions on clk, with and without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef SLIP_CRC8_FRAME_RECEIVER_TOP_MACROS_SVH
`define SLIP_CRC8_FRAME_RECEIVER_TOP_MACROS_SVH

// checked only out of reset
`define SLIPCRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SLIPCRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/slipcrc_pkg.sv
// ---------------------------------------------------------------------------
// SLIP CRC-8 frame receiver package
// Framing codes, status codes, result record and the CRC-8 byte update.
// ---------------------------------------------------------------------------
package slipcrc_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 64;
  localparam int unsigned CNT_W           = 7;

  localparam logic [7:0] SLIP_END      = 8'hC0;
  localparam logic [7:0] LINE_ESC      = 8'hDB;
  localparam logic [7:0] LINE_ESC_END  = 8'hDC;
  localparam logic [7:0] LINE_ESC_ESC  = 8'hDD;
  localparam logic [7:0] CRC_POLY      = 8'h07;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;
  localparam logic RES_PAYLOAD = 1'b0;
  localparam logic RES_REPORT  = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_SHORT    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    status_t     frame_status;
    logic [4:0]  sender_address;
    logic [31:0] sequence_number;
    logic [4:0]  word_count;
  } result_t;

  function automatic logic [7:0] crc8_update(logic [7:0] c, logic [7:0] b);
    logic [7:0] v;
    v = c ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/slipcrc_core.sv
// ---------------------------------------------------------------------------
// SLIP CRC-8 frame receiver: frame core
// Escape decode, CRC-8, frame bookkeeping and sequence extension; one
// request per step.
// ---------------------------------------------------------------------------
module slipcrc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 kind,
  input  logic [7:0]           rx_byte,
  output logic                 res_valid,
  output slipcrc_pkg::result_t res
);
  import slipcrc_pkg::*;

  logic             escape_r, escape_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [7:0]       header_r, header_nxt;
  logic             overflow_r, overflow_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [1:0]       prev_r, prev_nxt;

  logic [7:0]       dec;
  logic [1:0]       cyc;
  logic [1:0]       cyc_delta;
  logic [CNT_W-1:0] cnt_m3;
  status_t          status;

  always_comb begin
    escape_nxt   = escape_r;
    crc_nxt      = crc_r;
    count_nxt    = count_r;
    held_nxt     = held_r;
    header_nxt   = header_r;
    overflow_nxt = overflow_r;
    seq_nxt      = seq_r;
    prev_nxt     = prev_r;
    res_valid    = 1'b0;
    res          = '0;

    dec = rx_byte;
    if (escape_r && rx_byte == LINE_ESC_END) begin
      dec = SLIP_END;
    end else if (escape_r && rx_byte == LINE_ESC_ESC) begin
      dec = LINE_ESC;
    end

    cyc       = header_r[6:5];
    cyc_delta = cyc - prev_r;
    cnt_m3    = count_r - CNT_W'(3);

    if (overflow_r) begin
      status = ST_OVERFLOW;
    end else if (count_r < CNT_W'(3)) begin
      status = ST_SHORT;
    end else if (crc_r != 8'h00) begin
      status = ST_CRC_ERR;
    end else begin
      status = ST_GOOD;
    end

    if (kind == KIND_CLEAR) begin
      seq_nxt  = '0;
      prev_nxt = '0;
    end else if (rx_byte == SLIP_END) begin
      escape_nxt = 1'b0;
      if (count_r != '0 || overflow_r) begin
        res_valid              = 1'b1;
        res.result_kind        = RES_REPORT;
        res.frame_status       = status;
        res.sender_address     = header_r[4:0];
        res.sequence_number    = seq_r;
        if (status == ST_GOOD) begin
          seq_nxt             = seq_r + {30'd0, cyc_delta};
          prev_nxt            = cyc;
          res.sequence_number = seq_nxt;
          res.word_count      = cnt_m3[5:1];
        end
        crc_nxt      = '0;
        count_nxt    = '0;
        overflow_nxt = 1'b0;
      end
    end else if (rx_byte == LINE_ESC) begin
      escape_nxt = 1'b1;
    end else begin
      escape_nxt = 1'b0;
      if (count_r >= CNT_W'(MAX_FRAME_BYTES)) begin
        overflow_nxt = 1'b1;
      end else begin
        if (count_r >= CNT_W'(3)) begin
          res_valid        = 1'b1;
          res.result_kind  = RES_PAYLOAD;
          res.payload_byte = held_r;
        end
        if (count_r == '0) begin
          header_nxt = dec;
        end
        crc_nxt   = crc8_update(crc_r, dec);
        held_nxt  = dec;
        count_nxt = count_r + CNT_W'(1);
      end
    end

    if (!step) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r   <= 1'b0;
      crc_r      <= '0;
      count_r    <= '0;
      held_r     <= '0;
      header_r   <= '0;
      overflow_r <= 1'b0;
      seq_r      <= '0;
      prev_r     <= '0;
    end else if (step) begin
      escape_r   <= escape_nxt;
      crc_r      <= crc_nxt;
      count_r    <= count_nxt;
      held_r     <= held_nxt;
      header_r   <= header_nxt;
      overflow_r <= overflow_nxt;
      seq_r      <= seq_nxt;
      prev_r     <= prev_nxt;
    end
  end

endmodule

// File: hw/rtl/slip_crc8_frame_receiver_top.sv
// ---------------------------------------------------------------------------
// SLIP CRC-8 frame receiver
// Path: input reg, core, result reg; a stalled result holds the input reg.
// Throughput: 1 request per cycle unless a result stalls; one-byte CRC-8 step.
// Reset: synchronous active-low rst_n clears frame state, sequence and valids.
// ---------------------------------------------------------------------------
`include "slip_crc8_frame_receiver_top_macros.svh"

module slip_crc8_frame_receiver_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_result_kind,
  output logic [7:0]           out_payload_byte,
  output logic [1:0]           out_frame_status,
  output logic [4:0]           out_sender_address,
  output logic [31:0]          out_sequence_number,
  output logic [4:0]           out_word_count
);
  import slipcrc_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_kind_r;
  logic [7:0] s1_byte_r;
  logic       advance;
  logic       core_valid;
  result_t    core_res;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  slipcrc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .kind     (s1_kind_r),
    .rx_byte  (s1_byte_r),
    .res_valid(core_valid),
    .res      (core_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (core_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_valid && in_ready) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_rx_byte;
    end
    if (core_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_res_r.result_kind;
  assign out_payload_byte    = out_res_r.payload_byte;
  assign out_frame_status    = out_res_r.frame_status;
  assign out_sender_address  = out_res_r.sender_address;
  assign out_sequence_number = out_res_r.sequence_number;
  assign out_word_count      = out_res_r.word_count;

  `SLIPCRC_ASSERT(a_payload_fields_zero, out_valid_r && out_res_r.result_kind == RES_PAYLOAD |-> out_res_r.frame_status == ST_GOOD && out_res_r.sequence_number == 32'd0 && out_res_r.word_count == 5'd0, "payload result carries report fields")
  `SLIPCRC_ASSERT(a_words_only_good, out_valid_r && out_res_r.word_count != 5'd0 |-> out_res_r.frame_status == ST_GOOD, "word count on a bad frame")
  `SLIPCRC_ASSERT(a_stall_blocks_input, s1_valid_r && out_valid_r && !out_ready |-> !in_ready && !advance, "input taken while result stalled")
  `SLIPCRC_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_r && !s1_valid_r, "valid set after reset")

endmodule

// File: test/slip_frame_checker.sv
// ---------------------------------------------------------------------------
// SLIP CRC-8 frame receiver checker
// Watches both channels, predicts each decoded payload byte and end-of-frame
// report from the accepted line bytes, and compares accepted results in order.
// ---------------------------------------------------------------------------
module slip_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_result_kind,
  input  logic [7:0]  out_payload_byte,
  input  logic [1:0]  out_frame_status,
  input  logic [4:0]  out_sender_address,
  input  logic [31:0] out_sequence_number,
  input  logic [4:0]  out_word_count,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import slipcrc_pkg::*;

  localparam int PRINT_LIMIT = 40;

  logic        esc_armed;
  logic [7:0]  crc_acc;
  logic [6:0]  n_decoded;
  logic [7:0]  last_byte;
  logic [7:0]  head_byte;
  logic        overrun;
  logic [31:0] seq_count;
  logic [1:0]  last_cycle;

  result_t pending_results[$];

  function automatic logic [7:0] crc_fold(logic [7:0] acc, logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatches < PRINT_LIMIT) $display("%0t checker: %s", $time, what);
    mismatches++;
  endtask

  task automatic close_frame();
    esc_armed = 1'b0;
    crc_acc   = 8'h00;
    n_decoded = 7'd0;
    overrun   = 1'b0;
  endtask

  task automatic decode_line_byte(logic kind, logic [7:0] raw);
    result_t    r;
    logic [7:0] d;
    logic [1:0] cyc;
    logic [1:0] step;
    logic [6:0] span;
    status_t    st;
    r = '0;
    if (kind == KIND_CLEAR) begin
      seq_count  = 32'd0;
      last_cycle = 2'd0;
    end else if (raw == SLIP_END) begin
      if (n_decoded != 7'd0 || overrun) begin
        if (overrun) st = ST_OVERFLOW;
        else if (n_decoded < 3) st = ST_SHORT;
        else if (crc_acc != 8'h00) st = ST_CRC_ERR;
        else st = ST_GOOD;
        if (st == ST_GOOD) begin
          cyc        = head_byte[6:5];
          step       = cyc - last_cycle;
          seq_count  = seq_count + step;
          last_cycle = cyc;
          span       = n_decoded - 7'd3;
          r.word_count = span[5:1];
        end
        r.result_kind     = RES_REPORT;
        r.frame_status    = st;
        r.sender_address  = head_byte[4:0];
        r.sequence_number = seq_count;
        pending_results.push_back(r);
      end
      close_frame();
    end else if (raw == LINE_ESC) begin
      esc_armed = 1'b1;
    end else begin
      d = raw;
      if (esc_armed) begin
        if (raw == LINE_ESC_END) d = SLIP_END;
        else if (raw == LINE_ESC_ESC) d = LINE_ESC;
        esc_armed = 1'b0;
      end
      if (n_decoded >= MAX_FRAME_BYTES) begin
        overrun = 1'b1;
      end else begin
        if (n_decoded >= 3) begin
          r.result_kind  = RES_PAYLOAD;
          r.payload_byte = last_byte;
          pending_results.push_back(r);
        end
        if (n_decoded == 7'd0) head_byte = d;
        crc_acc   = crc_fold(crc_acc, d);
        last_byte = d;
        n_decoded = n_decoded + 7'd1;
      end
    end
  endtask

  task automatic match_result();
    result_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch($sformatf("result with nothing expected: kind %0d byte %02h status %0d",
                              out_result_kind, out_payload_byte, out_frame_status));
      return;
    end
    want = pending_results.pop_front();
    if (out_result_kind !== want.result_kind)
      flag_mismatch($sformatf("result_kind got %0d want %0d",
                              out_result_kind, want.result_kind));
    if (out_payload_byte !== want.payload_byte)
      flag_mismatch($sformatf("payload_byte got %02h want %02h",
                              out_payload_byte, want.payload_byte));
    if (out_frame_status !== want.frame_status)
      flag_mismatch($sformatf("frame_status got %0d want %0d",
                              out_frame_status, want.frame_status));
    if (out_sender_address !== want.sender_address)
      flag_mismatch($sformatf("sender_address got %02h want %02h",
                              out_sender_address, want.sender_address));
    if (out_sequence_number !== want.sequence_number)
      flag_mismatch($sformatf("sequence_number got %0d want %0d",
                              out_sequence_number, want.sequence_number));
    if (out_word_count !== want.word_count)
      flag_mismatch($sformatf("word_count got %0d want %0d",
                              out_word_count, want.word_count));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      close_frame();
      last_byte  = 8'h00;
      head_byte  = 8'h00;
      seq_count  = 32'd0;
      last_cycle = 2'd0;
      pending_results.delete();
    end else begin
      // retire results before absorbing the request of the same edge
      if (out_valid && out_ready) match_result();
      if (in_valid && in_ready) decode_line_byte(in_kind, in_rx_byte);
    end
    outstanding <= pending_results.size();
  end

endmodule

// File: test/tb.sv
// ---------------------------------------------------------------------------
// SLIP CRC-8 frame receiver testbench
// Drives escaped line bytes with random idling on both channels: directed
// corner cases first, then mostly well-formed frames with random content
// mixed with bad CRCs, short and oversized frames, broken escapes and noise.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slipcrc_pkg::*;

  localparam int RESET_CYCLES   = 10;
  localparam int ITEM_TARGET    = 1400;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int SETTLE_CYCLES  = 16;

  typedef enum {FRAME_GOOD, FRAME_BAD_CRC, FRAME_RAW} frame_flavor_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = KIND_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_payload_byte;
  logic [1:0]  out_frame_status;
  logic [4:0]  out_sender_address;
  logic [31:0] out_sequence_number;
  logic [4:0]  out_word_count;

  int mismatches;
  int outstanding;
  int in_gap_max = 12;
  int out_gap_max = 12;
  int n_bytes_sent = 0;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  slip_crc8_frame_receiver_top u_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_kind, .in_rx_byte,
    .out_valid, .out_ready, .out_result_kind, .out_payload_byte,
    .out_frame_status, .out_sender_address, .out_sequence_number, .out_word_count
  );

  slip_frame_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_kind, .in_rx_byte,
    .out_valid, .out_ready, .out_result_kind, .out_payload_byte,
    .out_frame_status, .out_sender_address, .out_sequence_number, .out_word_count,
    .mismatches, .outstanding
  );

  function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] data);
    logic [7:0] v;
    v = acc ^ data;
    repeat (8) v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    return v;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return SLIP_END;
      1: return LINE_ESC;
      2: return LINE_ESC_END;
      3: return LINE_ESC_ESC;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(logic kind, logic [7:0] data);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_rx_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == KIND_BYTE) n_bytes_sent++;
  endtask

  task automatic send_decoded(logic [7:0] d);
    if (d == SLIP_END) begin
      send_item(KIND_BYTE, LINE_ESC);
      send_item(KIND_BYTE, LINE_ESC_END);
    end else if (d == LINE_ESC) begin
      send_item(KIND_BYTE, LINE_ESC);
      send_item(KIND_BYTE, LINE_ESC_ESC);
    end else begin
      send_item(KIND_BYTE, d);
    end
  endtask

  task automatic send_frame(int len, frame_flavor_t flavor);
    logic [7:0] d;
    logic [7:0] crc;
    crc = 8'h00;
    for (int i = 0; i < len; i++) begin
      if (i == len - 1 && flavor == FRAME_GOOD) d = crc;
      else if (i == len - 1 && flavor == FRAME_BAD_CRC) d = crc ^ 8'($urandom_range(1, 255));
      else d = rand_byte();
      crc = crc8_next(crc, d);
      send_decoded(d);
    end
    send_item(KIND_BYTE, SLIP_END);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 2;
      default: return 12;
    endcase
  endfunction

  // result side: stall a random number of cycles before taking each result
  initial begin
    int gap;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int pick;
    int len;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(KIND_CLEAR, 8'hFF);
    send_item(KIND_BYTE, SLIP_END);
    send_item(KIND_BYTE, LINE_ESC);
    send_item(KIND_BYTE, SLIP_END);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, SLIP_END);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_BYTE, LINE_ESC);
    send_item(KIND_BYTE, LINE_ESC_END);
    send_item(KIND_BYTE, LINE_ESC);
    send_item(KIND_BYTE, LINE_ESC_ESC);
    send_item(KIND_BYTE, LINE_ESC_END);
    send_item(KIND_BYTE, LINE_ESC_ESC);
    send_item(KIND_BYTE, LINE_ESC);
    send_item(KIND_BYTE, LINE_ESC);
    send_item(KIND_BYTE, 8'h41);
    send_item(KIND_BYTE, SLIP_END);
    send_frame(3, FRAME_GOOD);
    send_frame(2, FRAME_RAW);
    send_frame(4, FRAME_GOOD);
    send_item(KIND_CLEAR, 8'h00);

    // hold the line until every expected result is out
    drain_wait();

    while (n_bytes_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, MAX_FRAME_BYTES)
                                           : $urandom_range(3, 16);
        send_frame(len, FRAME_GOOD);
      end else if (pick < 65) begin
        send_frame($urandom_range(3, 20), FRAME_BAD_CRC);
      end else if (pick < 70) begin
        send_frame($urandom_range(1, 2), FRAME_RAW);
      end else if (pick < 72) begin
        send_frame($urandom_range(MAX_FRAME_BYTES + 1, MAX_FRAME_BYTES + 6), FRAME_RAW);
      end else if (pick < 79) begin
        repeat ($urandom_range(1, 6)) send_item(KIND_BYTE, rand_byte());
      end else if (pick < 85) begin
        repeat ($urandom_range(0, 4)) send_decoded(rand_byte());
        send_item(KIND_BYTE, LINE_ESC);
        case ($urandom_range(0, 2))
          0: send_item(KIND_BYTE, LINE_ESC);
          1: send_item(KIND_BYTE, SLIP_END);
          default: send_item(KIND_BYTE, 8'($urandom_range(0, 8'hBF)));
        endcase
        repeat ($urandom_range(0, 4)) send_decoded(rand_byte());
        send_item(KIND_BYTE, SLIP_END);
      end else if (pick < 89) begin
        if ($urandom_range(0, 1) == 1) send_item(KIND_BYTE, LINE_ESC);
        send_item(KIND_BYTE, SLIP_END);
      end else if (pick < 93) begin
        send_item(KIND_CLEAR, 8'($urandom));
      end else begin
        in_gap_max  = pick_gap_max();
        out_gap_max = pick_gap_max();
        if ($urandom_range(0, 2) == 0) drain_wait();
      end
    end

    drain_wait();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
